[sv/pnp_pkg.sv]
// ----------------------------------------------------------------------------
// pnp_pkg
// Shared types, widths and codes for the polyline nearest point block.
// ----------------------------------------------------------------------------
package pnp_pkg;

  // coordinate and derived widths
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;      // difference of two coordinates
  localparam int LEN_W   = 50;               // squared span length
  localparam int DOT_W   = 51;               // signed dot product
  localparam int DIST_W  = 50;               // squared distance
  localparam int INDEX_W = 10;               // reported span index

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index codes (address bit 2)
  localparam logic REG_QUERY_X = 1'b0;
  localparam logic REG_QUERY_Y = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN_A,
    S_LEN_B,
    S_DOT_A,
    S_DOT_B,
    S_DOT_SUM,
    S_DECIDE,
    S_DIVIDE,
    S_PLACE_X,
    S_PLACE_Y,
    S_DIST_X,
    S_DIST_Y,
    S_DIST_SUM,
    S_UPDATE,
    S_EMIT
  } pnp_state_e;

  // exact difference of two coordinates
  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    coord_diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

endpackage

[sv/pnp_if.sv]
// ----------------------------------------------------------------------------
// pnp_if
// Valid/ready channels for vertices in and nearest point results out.
// ----------------------------------------------------------------------------
interface pnp_vtx_if;
  logic                  valid;
  logic                  ready;
  pnp_pkg::coord_t       vertex_x;
  pnp_pkg::coord_t       vertex_y;
  logic                  last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pnp_res_if #(
  parameter int FRACTION_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [pnp_pkg::INDEX_W-1:0]  span_index;
  logic [FRACTION_BITS:0]       span_fraction;
  pnp_pkg::coord_t              near_x;
  pnp_pkg::coord_t              near_y;
  logic [pnp_pkg::DIST_W-1:0]   dist_squared;
  logic                         degenerate;

  modport source (output valid, span_index, span_fraction, near_x, near_y,
                  dist_squared, degenerate, input ready);
  modport sink   (input valid, span_index, span_fraction, near_x, near_y,
                  dist_squared, degenerate, output ready);
endinterface

[sv/pnp_mul.sv]
// ----------------------------------------------------------------------------
// pnp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pnp_mul #(
  parameter int W = 25
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] prod_o
);

  logic signed [2*W-1:0] prod_q;

  // one product per cycle, registered result in the next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[sv/pnp_div.sv]
// ----------------------------------------------------------------------------
// pnp_div
// Restoring divider: rounded num * 2^F / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pnp_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pnp_pkg::LEN_W-1:0] num_i,
  input  logic [pnp_pkg::LEN_W-1:0] den_i,
  output logic                      busy_o,
  output logic [FRACTION_BITS:0]    quot_o
);

  localparam int QW = FRACTION_BITS + 1;
  localparam int CW = $clog2(QW);

  logic [pnp_pkg::LEN_W-1:0] rem_q, rem_d;
  logic [QW-1:0]             quo_q, quo_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic [pnp_pkg::LEN_W:0]   shifted;
  logic [pnp_pkg::LEN_W:0]   trial;
  logic                      fits;
  logic [QW:0]               rounded;

  // one restoring step
  assign shifted = {rem_q, 1'b0};
  assign trial   = shifted - {1'b0, den_i};
  assign fits    = shifted >= {1'b0, den_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = num_i;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial[pnp_pkg::LEN_W-1:0] : shifted[pnp_pkg::LEN_W-1:0];
      quo_d = {quo_q[QW-2:0], fits};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(FRACTION_BITS)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working remainder and quotient
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // round to nearest, ties up, by dropping the extra quotient bit
  assign rounded = {1'b0, quo_q} + (QW+1)'(1);
  assign quot_o  = rounded[QW:1];
  assign busy_o  = busy_q;

endmodule

[sv/polyline_nearest_point.sv]
// ----------------------------------------------------------------------------
// polyline_nearest_point
// Nearest point on a polyline to a configured query point, one vertex per
// transfer, using one shared multiplier and an iterative divider.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake        payload
//   vtx_i    in   valid / ready    vertex_x, vertex_y, last_vertex
//   res_o    out  valid / ready    span_index, span_fraction, near_x, near_y,
//                                  dist_squared, degenerate
//   apb      in   psel / penable   paddr, pwdata, pwrite -> prdata, pready
//
// A vertex that closes a span runs the shared multiplier sequence (length,
// dot product, placement, distance), and also the one-bit-per-cycle divider
// when the parameter falls strictly inside the span. A vertex that opens a
// polyline is only stored; a last vertex then passes through EMIT to load
// the result register. vtx_i is not ready while a span works.
// A result waiting on res_o stalls the block only when the next result is
// ready to load. Reset is asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module polyline_nearest_point #(
  parameter int MAX_SPANS     = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pnp_vtx_if.sink                      vtx_i,
  pnp_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pnp_pkg::APB_AW-1:0]   paddr,
  input  logic [pnp_pkg::APB_DW-1:0]   pwdata,
  output logic [pnp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int MW     = (FRACTION_BITS + 2 > pnp_pkg::DIFF_W) ?
                          FRACTION_BITS + 2 : pnp_pkg::DIFF_W;
  localparam int PW     = 2 * MW;
  localparam int ACC_W  = PW + 1;
  localparam int TW     = FRACTION_BITS + 1;
  localparam int CNT_W  = $clog2(MAX_SPANS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SPANS - 1);
  localparam logic [TW-1:0]    T_ONE   = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

  // configuration
  pnp_pkg::coord_t query_x_q, query_y_q;

  // sequencer
  pnp_pkg::pnp_state_e state_q, state_d;

  // per-polyline state
  pnp_pkg::coord_t          prev_x_q, prev_y_q;
  logic                     have_prev_q;
  logic [CNT_W-1:0]         span_cnt_q;
  logic [CNT_W-1:0]         best_span_q;
  logic [TW-1:0]            best_frac_q;
  pnp_pkg::coord_t          best_x_q, best_y_q;
  logic [pnp_pkg::DIST_W-1:0] best_dist_q;
  logic                     degen_q;

  // working registers for one span
  pnp_pkg::coord_t          cur_x_q, cur_y_q;
  logic                     last_q;
  pnp_pkg::diff_t           dx_q, dy_q, wx_q, wy_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [pnp_pkg::LEN_W-1:0] len_q;
  logic signed [pnp_pkg::DOT_W-1:0] dot_q;
  logic [TW-1:0]            t_q;
  pnp_pkg::coord_t          px_q, py_q;
  logic [pnp_pkg::DIST_W-1:0] dist_q;

  // result register
  logic                     res_valid_q;
  logic [CNT_W-1:0]         res_span_q;
  logic [TW-1:0]            res_frac_q;
  pnp_pkg::coord_t          res_x_q, res_y_q;
  logic [pnp_pkg::DIST_W-1:0] res_dist_q;
  logic                     res_degen_q;

  // sequencer outputs
  logic                     in_ready;
  logic                     div_start;
  logic signed [MW-1:0]     op_a, op_b;

  // datapath nets
  logic signed [PW-1:0]     prod;
  logic                     div_busy;
  logic [TW-1:0]            div_quot;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [PW-1:0]     rounded;
  logic signed [PW-1:0]     rounded_shr;
  logic [pnp_pkg::COORD_W-1:0] offset;
  logic                     in_xfer;
  logic                     res_free;
  logic                     dot_pos, dot_ge, len_zero;
  logic                     cfg_write;
  logic [CNT_W+pnp_pkg::INDEX_W-1:0] span_ext;

  assign in_xfer   = vtx_i.valid && in_ready;
  assign res_free  = !res_valid_q || res_o.ready;
  assign cfg_write = psel && penable && pwrite && pready;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        pnp_pkg::REG_QUERY_X: query_x_q <= pwdata[pnp_pkg::COORD_W-1:0];
        pnp_pkg::REG_QUERY_Y: query_y_q <= pwdata[pnp_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, sign extended
  always_comb begin
    case (paddr[2])
      pnp_pkg::REG_QUERY_X: prdata = pnp_pkg::APB_DW'(query_x_q);
      pnp_pkg::REG_QUERY_Y: prdata = pnp_pkg::APB_DW'(query_y_q);
      default:              prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // shared units
  // ------------------------------------------------------------------
  pnp_mul #(
    .W (MW)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  pnp_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dot_q[pnp_pkg::LEN_W-1:0]),
    .den_i   (len_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // accumulate two products
  assign acc_sum = acc_q + ACC_W'(prod);

  // projected coordinate offset: floor((d*t + half) / 2^F)
  assign rounded     = prod + HALF;
  assign rounded_shr = rounded >>> FRACTION_BITS;
  assign offset      = rounded_shr[pnp_pkg::COORD_W-1:0];

  // parameter range checks
  assign len_zero = (len_q == '0);
  assign dot_pos  = !dot_q[pnp_pkg::DOT_W-1] && (dot_q != '0);
  assign dot_ge   = dot_q[pnp_pkg::LEN_W-1:0] >= len_q;

  // ------------------------------------------------------------------
  // sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      pnp_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (have_prev_q) begin
            state_d = pnp_pkg::S_LEN_A;
          end else if (vtx_i.last_vertex) begin
            state_d = pnp_pkg::S_EMIT;
          end
        end
      end
      pnp_pkg::S_LEN_A:   state_d = pnp_pkg::S_LEN_B;
      pnp_pkg::S_LEN_B:   state_d = pnp_pkg::S_DOT_A;
      pnp_pkg::S_DOT_A:   state_d = pnp_pkg::S_DOT_B;
      pnp_pkg::S_DOT_B:   state_d = pnp_pkg::S_DOT_SUM;
      pnp_pkg::S_DOT_SUM: state_d = pnp_pkg::S_DECIDE;
      pnp_pkg::S_DECIDE: begin
        if (len_zero || !dot_pos || dot_ge) begin
          state_d = pnp_pkg::S_PLACE_X;
        end else begin
          state_d = pnp_pkg::S_DIVIDE;
        end
      end
      pnp_pkg::S_DIVIDE: begin
        if (!div_busy) begin
          state_d = pnp_pkg::S_PLACE_X;
        end
      end
      pnp_pkg::S_PLACE_X:  state_d = pnp_pkg::S_PLACE_Y;
      pnp_pkg::S_PLACE_Y:  state_d = pnp_pkg::S_DIST_X;
      pnp_pkg::S_DIST_X:   state_d = pnp_pkg::S_DIST_Y;
      pnp_pkg::S_DIST_Y:   state_d = pnp_pkg::S_DIST_SUM;
      pnp_pkg::S_DIST_SUM: state_d = pnp_pkg::S_UPDATE;
      pnp_pkg::S_UPDATE: begin
        state_d = last_q ? pnp_pkg::S_EMIT : pnp_pkg::S_IDLE;
      end
      pnp_pkg::S_EMIT: begin
        if (res_free) begin
          state_d = pnp_pkg::S_IDLE;
        end
      end
      default: state_d = pnp_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // sequencer: outputs and multiplier operand select
  // ------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    op_a      = '0;
    op_b      = '0;
    case (state_q)
      pnp_pkg::S_IDLE:    in_ready = 1'b1;
      pnp_pkg::S_LEN_A: begin
        op_a = MW'(dx_q);
        op_b = MW'(dx_q);
      end
      pnp_pkg::S_LEN_B: begin
        op_a = MW'(dy_q);
        op_b = MW'(dy_q);
      end
      pnp_pkg::S_DOT_A: begin
        op_a = MW'(wx_q);
        op_b = MW'(dx_q);
      end
      pnp_pkg::S_DOT_B: begin
        op_a = MW'(wy_q);
        op_b = MW'(dy_q);
      end
      pnp_pkg::S_DECIDE: begin
        div_start = !(len_zero || !dot_pos || dot_ge);
      end
      pnp_pkg::S_PLACE_X: begin
        op_a = MW'(dx_q);
        op_b = MW'(t_q);
      end
      pnp_pkg::S_PLACE_Y: begin
        op_a = MW'(dy_q);
        op_b = MW'(t_q);
      end
      pnp_pkg::S_DIST_X: begin
        op_a = MW'(pnp_pkg::coord_diff(query_x_q, px_q));
        op_b = MW'(pnp_pkg::coord_diff(query_x_q, px_q));
      end
      pnp_pkg::S_DIST_Y: begin
        op_a = MW'(pnp_pkg::coord_diff(query_y_q, py_q));
        op_b = MW'(pnp_pkg::coord_diff(query_y_q, py_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pnp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------------------
  // span working registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      pnp_pkg::S_IDLE: begin
        if (in_xfer) begin
          cur_x_q <= vtx_i.vertex_x;
          cur_y_q <= vtx_i.vertex_y;
          last_q  <= vtx_i.last_vertex;
          dx_q    <= pnp_pkg::coord_diff(vtx_i.vertex_x, prev_x_q);
          dy_q    <= pnp_pkg::coord_diff(vtx_i.vertex_y, prev_y_q);
          wx_q    <= pnp_pkg::coord_diff(query_x_q, prev_x_q);
          wy_q    <= pnp_pkg::coord_diff(query_y_q, prev_y_q);
        end
      end
      pnp_pkg::S_LEN_B:   acc_q <= ACC_W'(prod);
      pnp_pkg::S_DOT_A:   len_q <= acc_sum[pnp_pkg::LEN_W-1:0];
      pnp_pkg::S_DOT_B:   acc_q <= ACC_W'(prod);
      pnp_pkg::S_DOT_SUM: dot_q <= acc_sum[pnp_pkg::DOT_W-1:0];
      pnp_pkg::S_DECIDE: begin
        if (len_zero || !dot_pos) begin
          t_q <= '0;
        end else if (dot_ge) begin
          t_q <= T_ONE;
        end
      end
      pnp_pkg::S_DIVIDE: begin
        if (!div_busy) begin
          t_q <= div_quot;
        end
      end
      pnp_pkg::S_PLACE_Y: px_q <= prev_x_q + offset;
      pnp_pkg::S_DIST_X:  py_q <= prev_y_q + offset;
      pnp_pkg::S_DIST_Y:  acc_q <= ACC_W'(prod);
      // the squared distance never exceeds 2^49, so no saturation is needed
      pnp_pkg::S_DIST_SUM: dist_q <= acc_sum[pnp_pkg::DIST_W-1:0];
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // per-polyline state: previous vertex, span count, best candidate
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      span_cnt_q  <= '0;
      best_span_q <= '0;
      best_frac_q <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_dist_q <= pnp_pkg::DIST_MAX;
      degen_q     <= 1'b0;
    end else begin
      case (state_q)
        pnp_pkg::S_IDLE: begin
          if (in_xfer && !have_prev_q) begin
            if (vtx_i.last_vertex) begin
              // lone vertex: report it as is
              best_x_q <= vtx_i.vertex_x;
              best_y_q <= vtx_i.vertex_y;
              degen_q  <= 1'b1;
            end else begin
              prev_x_q    <= vtx_i.vertex_x;
              prev_y_q    <= vtx_i.vertex_y;
              have_prev_q <= 1'b1;
            end
          end
        end
        pnp_pkg::S_UPDATE: begin
          // first span always wins, later ones only when strictly closer
          if (span_cnt_q == '0 || dist_q < best_dist_q) begin
            best_span_q <= span_cnt_q;
            best_frac_q <= t_q;
            best_x_q    <= px_q;
            best_y_q    <= py_q;
            best_dist_q <= dist_q;
          end
          if (span_cnt_q < CNT_MAX) begin
            span_cnt_q <= span_cnt_q + CNT_W'(1);
          end
          prev_x_q    <= cur_x_q;
          prev_y_q    <= cur_y_q;
          have_prev_q <= 1'b1;
        end
        pnp_pkg::S_EMIT: begin
          if (res_free) begin
            prev_x_q    <= '0;
            prev_y_q    <= '0;
            have_prev_q <= 1'b0;
            span_cnt_q  <= '0;
            best_span_q <= '0;
            best_frac_q <= '0;
            best_x_q    <= '0;
            best_y_q    <= '0;
            best_dist_q <= pnp_pkg::DIST_MAX;
            degen_q     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == pnp_pkg::S_EMIT && res_free) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pnp_pkg::S_EMIT && res_free) begin
      res_span_q  <= best_span_q;
      res_frac_q  <= best_frac_q;
      res_x_q     <= best_x_q;
      res_y_q     <= best_y_q;
      res_dist_q  <= degen_q ? pnp_pkg::DIST_MAX : best_dist_q;
      res_degen_q <= degen_q;
    end
  end

  assign span_ext = {{pnp_pkg::INDEX_W{1'b0}}, res_span_q};

  assign vtx_i.ready         = in_ready;
  assign res_o.valid         = res_valid_q;
  assign res_o.span_index    = span_ext[pnp_pkg::INDEX_W-1:0];
  assign res_o.span_fraction = res_frac_q;
  assign res_o.near_x        = res_x_q;
  assign res_o.near_y        = res_y_q;
  assign res_o.dist_squared  = res_dist_q;
  assign res_o.degenerate    = res_degen_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == pnp_pkg::S_DIVIDE))
    else $error("divider busy outside the divide state");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pnp_pkg::S_UPDATE) |-> (t_q <= T_ONE))
    else $error("span parameter above one");

  a_degen_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_degen_q) |->
      (res_dist_q == pnp_pkg::DIST_MAX && res_span_q == '0 && res_frac_q == '0))
    else $error("degenerate result with non-saturated fields");

  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(state_q) == pnp_pkg::S_EMIT))
    else $error("result loaded outside the emit state");

endmodule
